// File: rtl/cpid_pkg.sv
// Package: widths, register codes and fixed-point helpers for the balance controller.
`timescale 1ns / 1ps
package cpid_pkg;

  localparam int COUNT_WIDTH = 16;
  localparam int PWM_TOP     = 255;
  localparam int DUTY_W      = 8;
  localparam int ADC_W       = 10;
  localparam int GAIN_W      = 24;
  localparam int PERIOD_W    = 8;
  localparam int IDX_W       = 3;
  localparam int ACC_W       = 32;
  localparam int ERR_W       = ADC_W + 1;
  localparam int DIFF_W      = ERR_W + 1;
  localparam int PDIFF_W     = COUNT_WIDTH + 1;
  localparam int ADD_W       = (PDIFF_W > ERR_W) ? PDIFF_W : ERR_W;
  localparam int MUL_W       = ACC_W + 1;
  localparam int FRAC_W      = 16;
  localparam int PROD_W      = MUL_W + GAIN_W - FRAC_W + 1;
  localparam int SUM_W       = PROD_W + 3;
  localparam int S_DATA_W    = 16;
  localparam int M_DATA_W    = 16;

  localparam logic [ADC_W-1:0]    SETPOINT_RST = ADC_W'(506);
  localparam logic [GAIN_W-1:0]   ANGLE_KP_RST = GAIN_W'(697958);
  localparam logic [GAIN_W-1:0]   ANGLE_KI_RST = GAIN_W'(1704);
  localparam logic [GAIN_W-1:0]   ANGLE_KD_RST = GAIN_W'(3770286);
  localparam logic [GAIN_W-1:0]   POS_KP_RST   = GAIN_W'(458752);
  localparam logic [GAIN_W-1:0]   POS_KI_RST   = GAIN_W'(0);
  localparam logic [GAIN_W-1:0]   POS_KD_RST   = GAIN_W'(0);
  localparam logic [PERIOD_W-1:0] PERIOD_RST   = PERIOD_W'(5);

  typedef enum logic {
    OP_TICK = 1'b0,
    OP_EDGE = 1'b1
  } cpid_op_t;

  typedef enum logic [IDX_W-1:0] {
    REG_ANGLE_SETPOINT = 3'd0,
    REG_ANGLE_KP       = 3'd1,
    REG_ANGLE_KI       = 3'd2,
    REG_ANGLE_KD       = 3'd3,
    REG_POS_KP         = 3'd4,
    REG_POS_KI         = 3'd5,
    REG_POS_KD         = 3'd6,
    REG_OUTER_PERIOD   = 3'd7
  } cpid_reg_t;

  typedef struct packed {
    logic signed [ERR_W-1:0]       err;
    logic signed [DIFF_W-1:0]      diff;
    logic signed [ACC_W-1:0]       aint;
    logic signed [COUNT_WIDTH-1:0] delta;
    logic signed [PDIFF_W-1:0]     pdiff;
    logic signed [ACC_W-1:0]       pint;
  } cpid_terms_t;

  // accumulate with clamp to signed 32 bits
  function automatic logic signed [ACC_W-1:0] sat_add(logic signed [ACC_W-1:0] acc,
                                                      logic signed [ADD_W-1:0] v);
    logic signed [ACC_W:0] s;
    s = (ACC_W+1)'(acc) + (ACC_W+1)'(v);
    if (s[ACC_W] != s[ACC_W-1]) begin
      return s[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
    end
    return s[ACC_W-1:0];
  endfunction

  // Q8.16 gain times x, magnitude truncated toward zero
  function automatic logic signed [PROD_W-1:0] gain_mul(logic [GAIN_W-1:0] g,
                                                       logic signed [MUL_W-1:0] x);
    logic [MUL_W-1:0]        mag;
    logic [MUL_W+GAIN_W-1:0] p;
    logic [PROD_W-2:0]       q;
    mag = x[MUL_W-1] ? MUL_W'(-x) : MUL_W'(x);
    p   = {{GAIN_W{1'b0}}, mag} * {{MUL_W{1'b0}}, g};
    q   = p[MUL_W+GAIN_W-1:FRAC_W];
    return x[MUL_W-1] ? -signed'({1'b0, q}) : signed'({1'b0, q});
  endfunction

endpackage

// File: rtl/cpid_state.sv
// Loop state: encoder count, errors, integrals, decimation counter and the first stage register.
`timescale 1ns / 1ps
module cpid_state (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           accept,
  input  logic                           op,
  input  logic [cpid_pkg::ADC_W-1:0]     adc_sample,
  input  logic                           b_phase,
  input  logic [cpid_pkg::ADC_W-1:0]     angle_setpoint,
  input  logic [cpid_pkg::PERIOD_W-1:0]  outer_period,
  input  logic                           load,
  output cpid_pkg::cpid_terms_t          terms,
  output logic                           valid
);
  import cpid_pkg::*;

  logic        [COUNT_WIDTH-1:0] encoder_count;
  logic        [COUNT_WIDTH-1:0] last_count;
  logic signed [ERR_W-1:0]       prev_error;
  logic signed [ACC_W-1:0]       angle_integral;
  logic signed [ACC_W-1:0]       pos_integral;
  logic signed [COUNT_WIDTH-1:0] prev_pos_delta;
  logic        [PERIOD_W-1:0]    tick_count;

  logic                          tick;
  logic signed [ERR_W-1:0]       err;
  logic signed [DIFF_W-1:0]      diff;
  logic signed [ACC_W-1:0]       angle_integral_next;
  logic        [PERIOD_W-1:0]    tick_inc;
  logic                          outer;
  logic signed [COUNT_WIDTH-1:0] delta;
  logic signed [PDIFF_W-1:0]     pdiff;
  logic signed [ACC_W-1:0]       pos_integral_next;

  assign tick  = accept && (cpid_op_t'(op) == OP_TICK);
  assign err   = signed'(ERR_W'({1'b0, adc_sample}) - ERR_W'({1'b0, angle_setpoint}));
  assign diff  = DIFF_W'(err) - DIFF_W'(prev_error);
  assign angle_integral_next = sat_add(angle_integral, ADD_W'(err));
  assign tick_inc = tick_count + PERIOD_W'(1);
  assign outer    = (tick_inc == outer_period);
  assign delta    = signed'(encoder_count - last_count);
  assign pdiff    = PDIFF_W'(delta) - PDIFF_W'(prev_pos_delta);
  assign pos_integral_next = sat_add(pos_integral, ADD_W'(delta));

  always_ff @(posedge clk) begin
    if (rst) begin
      encoder_count  <= '0;
      last_count     <= '0;
      prev_error     <= '0;
      angle_integral <= '0;
      pos_integral   <= '0;
      prev_pos_delta <= '0;
      tick_count     <= '0;
    end else if (accept) begin
      if (cpid_op_t'(op) == OP_EDGE) begin
        encoder_count <= b_phase ? encoder_count - COUNT_WIDTH'(1)
                                 : encoder_count + COUNT_WIDTH'(1);
      end else begin
        prev_error     <= err;
        angle_integral <= angle_integral_next;
        if (outer) begin
          tick_count     <= '0;
          last_count     <= encoder_count;
          pos_integral   <= pos_integral_next;
          prev_pos_delta <= delta;
        end else begin
          tick_count <= tick_inc;
        end
      end
    end
  end

  // first stage register; outer terms are zero when the outer loop is not due
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= tick;
    end
  end

  always_ff @(posedge clk) begin
    if (load && tick) begin
      terms.err   <= err;
      terms.diff  <= diff;
      terms.aint  <= angle_integral_next;
      terms.delta <= outer ? delta : '0;
      terms.pdiff <= outer ? pdiff : '0;
      terms.pint  <= outer ? pos_integral_next : '0;
    end
  end

`ifndef ASSERT_OFF
  a_edge_keeps_ticks: assert property (@(posedge clk) disable iff (rst)
    (accept && cpid_op_t'(op) == OP_EDGE) |=> $stable(tick_count) && $stable(angle_integral))
    else $error("encoder edge changed loop state");
  a_tick_keeps_count: assert property (@(posedge clk) disable iff (rst)
    tick |=> $stable(encoder_count))
    else $error("control tick changed encoder count");
  a_outer_restarts: assert property (@(posedge clk) disable iff (rst)
    (tick && outer) |=> tick_count == '0 && last_count == encoder_count)
    else $error("outer update did not restart decimation");
`endif

endmodule

// File: rtl/cascaded_pid_balance_controller_unit.sv
// Top level: config registers, gain product stage and drive output register.
// A control tick item passes the state, product and output registers to the master side.
// Throughput: one item per cycle unless m_tready stalls; encoder edge items likewise, no result.
// The three stages (state update, six gain products, sum and limit) advance independently.
// Reset (rst, synchronous) clears all loop state and loads the default gains and setpoint.
`timescale 1ns / 1ps
module cascaded_pid_balance_controller_unit (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [cpid_pkg::S_DATA_W-1:0] s_tdata,   // [9:0] adc_sample, [10] b_phase
  input  logic                          s_tuser,   // [0] op
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [cpid_pkg::M_DATA_W-1:0] m_tdata,   // [0] motor_forward, [8:1] duty
  output logic                          m_tuser,   // [0] saturated
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [cpid_pkg::IDX_W-1:0]    cfg_index,
  input  logic [cpid_pkg::GAIN_W-1:0]   cfg_data
);
  import cpid_pkg::*;

  logic [ADC_W-1:0]    angle_setpoint;
  logic [GAIN_W-1:0]   angle_kp;
  logic [GAIN_W-1:0]   angle_ki;
  logic [GAIN_W-1:0]   angle_kd;
  logic [GAIN_W-1:0]   pos_kp;
  logic [GAIN_W-1:0]   pos_ki;
  logic [GAIN_W-1:0]   pos_kd;
  logic [PERIOD_W-1:0] outer_period;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      angle_setpoint <= SETPOINT_RST;
      angle_kp       <= ANGLE_KP_RST;
      angle_ki       <= ANGLE_KI_RST;
      angle_kd       <= ANGLE_KD_RST;
      pos_kp         <= POS_KP_RST;
      pos_ki         <= POS_KI_RST;
      pos_kd         <= POS_KD_RST;
      outer_period   <= PERIOD_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cpid_reg_t'(cfg_index))
        REG_ANGLE_SETPOINT: angle_setpoint <= cfg_data[ADC_W-1:0];
        REG_ANGLE_KP:       angle_kp       <= cfg_data;
        REG_ANGLE_KI:       angle_ki       <= cfg_data;
        REG_ANGLE_KD:       angle_kd       <= cfg_data;
        REG_POS_KP:         pos_kp         <= cfg_data;
        REG_POS_KI:         pos_ki         <= cfg_data;
        REG_POS_KD:         pos_kd         <= cfg_data;
        REG_OUTER_PERIOD:   outer_period   <= cfg_data[PERIOD_W-1:0];
        default: ;
      endcase
    end
  end

  // stage advance: a stage loads when the one after it is empty or moving
  logic adv_out;
  logic adv2;
  logic adv1;
  logic v1;
  logic v2;
  logic accept;
  cpid_terms_t terms;

  assign adv_out  = !m_tvalid || m_tready;
  assign adv2     = !v2 || adv_out;
  assign adv1     = !v1 || adv2;
  assign s_tready = adv1;
  assign accept   = s_tvalid && s_tready;

  cpid_state u_state (
    .clk            (clk),
    .rst            (rst),
    .accept         (accept),
    .op             (s_tuser),
    .adc_sample     (s_tdata[ADC_W-1:0]),
    .b_phase        (s_tdata[ADC_W]),
    .angle_setpoint (angle_setpoint),
    .outer_period   (outer_period),
    .load           (adv1),
    .terms          (terms),
    .valid          (v1)
  );

  // product stage
  logic signed [PROD_W-1:0] p_akp;
  logic signed [PROD_W-1:0] p_aki;
  logic signed [PROD_W-1:0] p_akd;
  logic signed [PROD_W-1:0] p_pkp;
  logic signed [PROD_W-1:0] p_pki;
  logic signed [PROD_W-1:0] p_pkd;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (adv2) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv2 && v1) begin
      p_akp <= gain_mul(angle_kp, MUL_W'(terms.err));
      p_aki <= gain_mul(angle_ki, MUL_W'(terms.aint));
      p_akd <= gain_mul(angle_kd, MUL_W'(terms.diff));
      p_pkp <= gain_mul(pos_kp, MUL_W'(terms.delta));
      p_pki <= gain_mul(pos_ki, MUL_W'(terms.pint));
      p_pkd <= gain_mul(pos_kd, MUL_W'(terms.pdiff));
    end
  end

  // sum, magnitude and PWM limit
  logic signed [SUM_W-1:0] drive;
  logic        [SUM_W-1:0] mag;
  logic                    sat;
  logic                    motor_forward;
  logic [DUTY_W-1:0]       duty;
  logic                    saturated;

  assign drive = SUM_W'(p_akp) + SUM_W'(p_aki) + SUM_W'(p_akd)
               - SUM_W'(p_pkp) - SUM_W'(p_pki) - SUM_W'(p_pkd);
  assign mag   = drive[SUM_W-1] ? SUM_W'(-drive) : SUM_W'(drive);
  assign sat   = mag > SUM_W'(PWM_TOP);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (adv_out) begin
      m_tvalid <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (adv_out && v2) begin
      motor_forward <= !drive[SUM_W-1] && (drive != '0);
      duty          <= sat ? DUTY_W'(PWM_TOP) : mag[DUTY_W-1:0];
      saturated     <= sat;
    end
  end

  assign m_tdata = {{(M_DATA_W-DUTY_W-1){1'b0}}, duty, motor_forward};
  assign m_tuser = saturated;

`ifndef ASSERT_OFF
  a_edge_no_result: assert property (@(posedge clk) disable iff (rst)
    (accept && cpid_op_t'(s_tuser) == OP_EDGE) |=> !v1)
    else $error("encoder edge entered the result pipeline");
  a_prod_hold: assert property (@(posedge clk) disable iff (rst)
    (v2 && !adv2) |=> v2 && $stable(p_akp) && $stable(p_pkp))
    else $error("product stage lost an item under stall");
  a_sat_duty: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && saturated) |-> duty == DUTY_W'(PWM_TOP))
    else $error("saturated result without full duty");
  a_zero_reverse: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && duty == '0) |-> !motor_forward)
    else $error("zero duty marked forward");
`endif

endmodule
